### hw/rtl/ihex_pkg.sv
package ihex_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // status codes
    localparam logic [3:0] STAT_OK         = 4'd0;
    localparam logic [3:0] STAT_NOT_RECORD = 4'd1;
    localparam logic [3:0] STAT_BAD_HEX    = 4'd2;
    localparam logic [3:0] STAT_LENGTH     = 4'd3;
    localparam logic [3:0] STAT_CHECKSUM   = 4'd4;
    localparam logic [3:0] STAT_RANGE      = 4'd5;
    localparam logic [3:0] STAT_TYPE       = 4'd6;
    localparam logic [3:0] STAT_NO_DATA    = 4'd7;
    localparam logic [3:0] STAT_TOO_LONG   = 4'd8;
    localparam logic [3:0] STAT_TOO_SHORT  = 4'd9;

    // record types
    localparam logic [7:0] REC_DATA      = 8'h00;
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_SEG       = 8'h02;
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_LIN       = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [8:0]  MIN_LINE   = 9'd11;
    localparam logic [8:0]  LEN_MAX    = 9'd511;
    localparam logic [32:0] ADDR_LIMIT = 33'h10000;

    typedef struct packed {
        logic       take_char;
        logic       clear_line;
        logic       reset_all;
        logic       set_failed;
        logic       set_seg;
        logic       set_seen;
        logic       cap_base;
        logic       idx_clear;
        logic       idx_inc;
        logic       out_load;
        logic [1:0] out_kind;
        logic [3:0] out_status;
        logic       out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic       line_empty;
        logic       failed;
        logic       seen_data;
        logic       out_free;
        logic       count_zero;
        logic       idx_last;
        logic [3:0] chk_status;
        logic [7:0] rec_type;
    } dp_stat_t;

endpackage

### hw/rtl/ihex_ram.sv
module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 37
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ihex_dpath.sv
module ihex_dpath import ihex_pkg::*; #(
    parameter int MAX_DATA = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_code,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int DEPTH = MAX_DATA + 5;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(DEPTH + 1);

    // line state
    logic [8:0]    len_reg, len_next;
    logic          phase_reg, phase_next;
    logic [3:0]    held_reg, held_next;
    logic [BW-1:0] bidx_reg, bidx_next;
    logic [7:0]    sum_reg, sum_next;
    logic          colon_reg, colon_next;
    logic          bad_reg, bad_next;
    logic          over_reg, over_next;
    logic [31:0]   seg_reg, seg_next;
    logic          seen_reg, seen_next;
    logic          failed_reg, failed_next;
    logic          valid_reg, valid_next;

    // header and tail bytes kept beside the store
    logic [7:0]    count_reg, offh_reg, offl_reg, type_reg, d0_reg, d1_reg;
    logic [7:0]    lb1_reg, lb2_reg, lb3_reg;
    logic [15:0]   base_reg;
    logic [BW-1:0] idx_reg;

    // output payload
    logic [1:0]    kind_reg;
    logic [15:0]   addr_reg;
    logic [7:0]    data_reg;
    logic [3:0]    status_reg;
    logic          last_reg;

    logic [3:0]    nib;
    logic          nib_bad;
    logic [7:0]    new_byte;
    logic          byte_done;
    logic          byte_store;
    logic [7:0]    ram_rdata;
    logic [32:0]   range_sum;
    logic [3:0]    chk;

    always_comb
    begin
        nib     = 4'd0;
        nib_bad = 1'b0;
        if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            nib = char_code[3:0];
        end
        else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                 (char_code >= 8'h61 && char_code <= 8'h66))
        begin
            nib = char_code[3:0] + 4'd9;
        end
        else
        begin
            nib_bad = 1'b1;
        end
    end

    assign new_byte   = {held_reg, nib};
    assign byte_done  = cmd.take_char && (len_reg != 9'd0) && phase_reg;
    assign byte_store = byte_done && (bidx_reg < BW'(DEPTH));

    ihex_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (byte_store),
        .waddr (bidx_reg[AW-1:0]),
        .wdata (new_byte),
        .raddr (AW'(idx_reg + BW'(4))),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        len_next    = len_reg;
        phase_next  = phase_reg;
        held_next   = held_reg;
        bidx_next   = bidx_reg;
        sum_next    = sum_reg;
        colon_next  = colon_reg;
        bad_next    = bad_reg;
        over_next   = over_reg;
        seg_next    = seg_reg;
        seen_next   = seen_reg;
        failed_next = failed_reg;
        if (cmd.reset_all || cmd.clear_line)
        begin
            len_next   = 9'd0;
            phase_next = 1'b0;
            held_next  = 4'd0;
            bidx_next  = '0;
            sum_next   = 8'd0;
            colon_next = 1'b0;
            bad_next   = 1'b0;
            over_next  = 1'b0;
        end
        if (cmd.reset_all)
        begin
            seg_next    = 32'd0;
            seen_next   = 1'b0;
            failed_next = 1'b0;
        end
        else
        begin
            if (cmd.take_char)
            begin
                len_next = (len_reg == LEN_MAX) ? len_reg : len_reg + 9'd1;
                if (len_reg == 9'd0)
                begin
                    // first character only marks the record start
                    colon_next = (char_code == CH_COLON);
                end
                else
                begin
                    if (nib_bad)
                    begin
                        bad_next = 1'b1;
                    end
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        held_next  = nib;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        sum_next   = sum_reg + new_byte;
                        if (bidx_reg < BW'(DEPTH))
                        begin
                            bidx_next = bidx_reg + BW'(1);
                        end
                        else
                        begin
                            over_next = 1'b1;
                        end
                    end
                end
            end
            if (cmd.set_seg)
            begin
                seg_next = (type_reg == REC_SEG) ? {12'd0, d0_reg, d1_reg, 4'd0}
                                                 : {d0_reg, d1_reg, 16'd0};
            end
            if (cmd.set_seen)
            begin
                seen_next = 1'b1;
            end
            if (cmd.set_failed)
            begin
                failed_next = 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= 9'd0;
            phase_reg  <= 1'b0;
            held_reg   <= 4'd0;
            bidx_reg   <= '0;
            sum_reg    <= 8'd0;
            colon_reg  <= 1'b0;
            bad_reg    <= 1'b0;
            over_reg   <= 1'b0;
            seg_reg    <= 32'd0;
            seen_reg   <= 1'b0;
            failed_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            bidx_reg   <= bidx_next;
            sum_reg    <= sum_next;
            colon_reg  <= colon_next;
            bad_reg    <= bad_next;
            over_reg   <= over_next;
            seg_reg    <= seg_next;
            seen_reg   <= seen_next;
            failed_reg <= failed_next;
            valid_reg  <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_store)
        begin
            unique case (bidx_reg)
                BW'(0):  count_reg <= new_byte;
                BW'(1):  offh_reg  <= new_byte;
                BW'(2):  offl_reg  <= new_byte;
                BW'(3):  type_reg  <= new_byte;
                BW'(4):  d0_reg    <= new_byte;
                BW'(5):  d1_reg    <= new_byte;
                default: ;
            endcase
        end
        if (byte_done)
        begin
            lb1_reg <= new_byte;
            lb2_reg <= lb1_reg;
            lb3_reg <= lb2_reg;
        end
        if (cmd.cap_base)
        begin
            base_reg <= seg_reg[15:0] + {offh_reg, offl_reg};
        end
        if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + BW'(1);
        end
        if (cmd.out_load)
        begin
            kind_reg   <= cmd.out_kind;
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
            if (cmd.out_kind == KIND_DATA)
            begin
                addr_reg <= base_reg + 16'(idx_reg);
                data_reg <= ram_rdata;
            end
            else if (cmd.out_kind == KIND_ENTRY)
            begin
                addr_reg <= {lb3_reg, lb2_reg};
                data_reg <= 8'd0;
            end
            else
            begin
                addr_reg <= 16'd0;
                data_reg <= 8'd0;
            end
        end
    end

    // record checks in priority order
    assign range_sum = {1'b0, seg_reg} + 33'({offh_reg, offl_reg}) + 33'(count_reg);

    always_comb
    begin
        priority if (!colon_reg || len_reg < MIN_LINE)
            chk = STAT_NOT_RECORD;
        else if (bad_reg || phase_reg)
            chk = STAT_BAD_HEX;
        else if (over_reg)
            chk = (9'(count_reg) > 9'(MAX_DATA)) ? STAT_TOO_LONG : STAT_LENGTH;
        else if (9'(bidx_reg) != 9'(count_reg) + 9'd5)
            chk = STAT_LENGTH;
        else if (sum_reg != 8'd0)
            chk = STAT_CHECKSUM;
        else if (type_reg >= REC_SEG && type_reg <= REC_START_LIN && count_reg < 8'd2)
            chk = STAT_TOO_SHORT;
        else if (type_reg == REC_DATA && range_sum > ADDR_LIMIT)
            chk = STAT_RANGE;
        else if (type_reg > REC_START_LIN)
            chk = STAT_TYPE;
        else
            chk = STAT_OK;
    end

    assign stat.line_empty = (len_reg == 9'd0);
    assign stat.failed     = failed_reg;
    assign stat.seen_data  = seen_reg;
    assign stat.out_free   = !valid_reg || m_tready;
    assign stat.count_zero = (count_reg == 8'd0);
    assign stat.idx_last   = (9'(idx_reg) + 9'd1 == 9'(count_reg));
    assign stat.chk_status = chk;
    assign stat.rec_type   = type_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, status_reg, data_reg, addr_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

### hw/rtl/ihex_ctrl.sv
module ihex_ctrl import ihex_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] char_code,
    input  logic       end_of_file,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;
    localparam logic [2:0] ST_ENTRY = 3'd5;
    localparam logic [2:0] ST_FINAL = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       eof_reg, eof_next;
    logic       accept;
    logic       is_space;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_space = (char_code == CH_CR) || (char_code == CH_SP) || (char_code == CH_TAB);

    always_comb
    begin
        state_next = state_reg;
        eof_next   = eof_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    eof_next = end_of_file;
                    if (end_of_file)
                    begin
                        if (stat.failed)
                            cmd.reset_all = 1'b1;
                        else if (stat.line_empty)
                            state_next = ST_FINAL;
                        else
                            state_next = ST_CHECK;
                    end
                    else if (!stat.failed)
                    begin
                        if (char_code == CH_NL)
                        begin
                            if (!stat.line_empty)
                                state_next = ST_CHECK;
                        end
                        else if (!is_space)
                        begin
                            cmd.take_char = 1'b1;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (stat.chk_status != STAT_OK)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    // line done unless results follow
                    cmd.clear_line = !eof_reg;
                    state_next     = eof_reg ? ST_FINAL : ST_IDLE;
                    unique case (stat.rec_type)
                        REC_DATA:
                        begin
                            cmd.set_seen = 1'b1;
                            if (!stat.count_zero)
                            begin
                                cmd.clear_line = 1'b0;
                                cmd.cap_base   = 1'b1;
                                cmd.idx_clear  = 1'b1;
                                state_next     = ST_RD;
                            end
                        end
                        REC_SEG, REC_LIN:
                        begin
                            cmd.set_seg = 1'b1;
                        end
                        REC_START_SEG, REC_START_LIN:
                        begin
                            cmd.clear_line = 1'b0;
                            state_next     = ST_ENTRY;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_DATA;
                    cmd.out_last = stat.idx_last && !eof_reg;
                    cmd.idx_inc  = 1'b1;
                    if (stat.idx_last)
                    begin
                        cmd.clear_line = !eof_reg;
                        state_next     = eof_reg ? ST_FINAL : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = KIND_ERROR;
                    cmd.out_status = stat.chk_status;
                    cmd.out_last   = 1'b1;
                    cmd.reset_all  = eof_reg;
                    cmd.set_failed = !eof_reg;
                    cmd.clear_line = !eof_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_ENTRY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = KIND_ENTRY;
                    cmd.out_last   = !eof_reg;
                    cmd.clear_line = !eof_reg;
                    state_next     = eof_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = stat.seen_data ? KIND_DONE : KIND_ERROR;
                    cmd.out_status = stat.seen_data ? STAT_OK : STAT_NO_DATA;
                    cmd.out_last   = 1'b1;
                    cmd.reset_all  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            eof_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eof_reg   <= eof_next;
        end
    end

`ifndef SYNTH
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded while output register busy");

    a_emit_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !stat.count_zero)
        else $error("data emission with zero count");

    a_err_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERR) |-> (stat.chk_status != STAT_OK))
        else $error("error state without failing check");
`endif

endmodule

### hw/rtl/intel_hex_record_parser_core.sv
// intel hex record parser: takes the file text one character per item on the
// s_ side (s_tlast marks end of file) and returns data bytes with addresses,
// entry addresses, a final load ok or a single error on the m_ side. closing
// a line runs a check step, then for each data byte of a type 00 record a
// registered read of the record store and a load of the output register, or
// a single output load for an entry, error or final result; every load waits
// while the output side stalls. the block takes no new item while a closed
// line is being worked off. after the first error all text is dropped until
// end of file, which then resets the block without a result.
module intel_hex_record_parser_core import ihex_pkg::*; #(
    parameter int MAX_DATA = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_code
    input  logic        s_tlast,    // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // load_address[15:0], data_byte[23:16], status[27:24], zero
    output logic [1:0]  m_tuser,    // result_kind
    output logic        m_tlast     // last_of_run
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: line close, record dispatch, result emission
    ihex_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .char_code   (s_tdata),
        .end_of_file (s_tlast),
        .stat        (stat),
        .cmd         (cmd)
    );

    // line assembly, record store, checks and output register
    ihex_dpath #(
        .MAX_DATA (MAX_DATA)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
